// ----- hw/rtl/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline task queue package
// Shared types, codes and constants for the deadline task queue and its RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

	// Default number of task slots.
	localparam int CAPACITY = 16;

	// Field widths fixed by the item formats.
	localparam int TIME_W  = 48;
	localparam int DELAY_W = 32;
	localparam int HND_W   = 8;
	localparam int ARG_W   = 32;
	localparam int SLOT_W  = 4;
	localparam int KIND_W  = 3;
	localparam int LIMIT_W = 5;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_SCHEDULE = 2'd0;
	localparam logic [1:0] MODE_CANCEL   = 2'd1;
	localparam logic [1:0] MODE_EXPIRE   = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_SCHEDULED    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TABLE_FULL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CANCELLED    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CANCEL_EMPTY = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIRED        = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DONE         = 3'd5;

	// Largest representable time, also the "queue empty" marker.
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// One input item.
	typedef struct packed {
		logic [1:0]         mode;
		logic [TIME_W-1:0]  now_ms;
		logic [DELAY_W-1:0] delay_ms;
		logic [HND_W-1:0]   handler_id;
		logic [ARG_W-1:0]   argument;
		logic [SLOT_W-1:0]  cancel_slot;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [HND_W-1:0]  fired_handler;
		logic [ARG_W-1:0]  fired_argument;
		logic [TIME_W-1:0] time_to_next;
		logic              last;
	} result_t;

	// One stored task as it sits in the slot RAM.
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [HND_W-1:0]  handler;
		logic [ARG_W-1:0]  argument;
	} entry_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND_FREE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtq_ram.sv -----
// ----------------------------------------------------------------------------
// Deadline task queue RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/deadline_task_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Deadline task queue
// Fixed-capacity table of timed tasks with schedule, cancel and expire
// operations; task payloads live in one RAM, occupancy in flip-flops.
// ----------------------------------------------------------------------------
// Usage:
// An operation is transferred on the item port when start is high and busy
// is low. Each result appears on the result port for exactly one cycle with
// result_strobe high; the receiver cannot stall, so every strobe is a
// completed transfer. The final result of an operation has last set.
// Cancel: one result, in the cycle after the transfer; busy never rises.
// Schedule: the free-slot search visits one slot per cycle from slot 0 up;
// the result follows the first free slot, or the last slot if all are full.
// Expire: every search for the earliest deadline streams all CAPACITY
// entries through the RAM read port, one per cycle, then through the read
// pipeline stage to the decision state. An expire that fires k tasks runs
// k+1 searches; each fired result and the closing done result follow a search.
// The expire limit register is written through cfg_valid/cfg_ready and is
// accepted only while the block is idle.
// Reset empties every slot and clears the limit; the RAM needs no clearing
// because entries are only used for occupied slots.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_task_queue_unit #(
	parameter int CAPACITY = dtq_pkg::CAPACITY
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire dtq_pkg::item_t                 item,
	output logic                                result_strobe,
	output dtq_pkg::result_t                    result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dtq_pkg::LIMIT_W-1:0]    cfg_data
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CS_W    = (IDX_W > dtq_pkg::SLOT_W) ? IDX_W : dtq_pkg::SLOT_W;
	localparam int ENTRY_W = $bits(dtq_pkg::entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	// Control state.
	dtq_pkg::state_t             state_q, state_d;
	logic [CAPACITY-1:0]         valid_q;
	logic [IDX_W-1:0]            scan_idx_q;
	logic                        scan_issue_q;
	logic [dtq_pkg::LIMIT_W-1:0] limit_q;
	logic [dtq_pkg::LIMIT_W-1:0] fired_q;
	logic                        result_strobe_q;
	logic                        best_found_q;

	// Read pipeline stage.
	logic                        rd_valid_s1;
	logic [IDX_W-1:0]            rd_idx_s1;
	logic                        rd_last_s1;

	// Payload registers.
	dtq_pkg::item_t              item_q;
	dtq_pkg::result_t            result_q;
	logic [IDX_W-1:0]            best_idx_q;
	dtq_pkg::entry_t             best_q;

	// RAM ports.
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	dtq_pkg::entry_t             ram_wdata;
	logic                        ram_re;
	logic [ENTRY_W-1:0]          ram_rdata;
	dtq_pkg::entry_t             rd_entry;

	// Decisions from the sequencer.
	logic                        emit;
	dtq_pkg::result_t            result_d;
	logic                        set_valid;
	logic                        clr_valid;
	logic [IDX_W-1:0]            valid_idx;
	logic                        begin_scan;
	logic                        begin_find;
	logic                        fire;
	logic                        take_item;

	// Derived values.
	logic [dtq_pkg::TIME_W:0]    dl_sum;
	logic [dtq_pkg::TIME_W-1:0]  dl_sat;
	logic [CS_W-1:0]             cs_ext;
	logic                        cs_in_range;
	logic [IDX_W-1:0]            cs_idx;
	logic                        limit_hit;
	logic                        overdue;
	logic                        better;

	dtq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	assign rd_entry = dtq_pkg::entry_t'(ram_rdata);

	// Deadline of a new task, held at the largest time on overflow.
	assign dl_sum = {1'b0, item_q.now_ms}
		+ {{(dtq_pkg::TIME_W + 1 - dtq_pkg::DELAY_W){1'b0}}, item_q.delay_ms};
	assign dl_sat = dl_sum[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX
		: dl_sum[dtq_pkg::TIME_W-1:0];

	// Cancel handle, checked against the table size.
	assign cs_ext      = CS_W'(item.cancel_slot);
	assign cs_in_range = (CS_W + 1)'(cs_ext) < (CS_W + 1)'(CAPACITY);
	assign cs_idx      = cs_ext[IDX_W-1:0];

	assign limit_hit = (limit_q != '0) && (fired_q == limit_q);
	assign overdue   = item_q.now_ms > best_q.deadline;

	// A valid entry replaces the best so far only when strictly earlier,
	// so the lower index wins ties.
	assign better = valid_q[rd_idx_s1]
		&& (!best_found_q || (rd_entry.deadline < best_q.deadline));

	assign ram_re    = (state_q == dtq_pkg::ST_SCAN) && scan_issue_q;
	assign ram_waddr = scan_idx_q;
	assign ram_wdata = '{deadline: dl_sat, handler: item_q.handler_id,
		argument: item_q.argument};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		result_d   = '0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		valid_idx  = scan_idx_q;
		begin_scan = 1'b0;
		begin_find = 1'b0;
		fire       = 1'b0;
		take_item  = 1'b0;
		ram_we     = 1'b0;
		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				if (start) begin
					take_item = 1'b1;
					case (item.mode)
						dtq_pkg::MODE_SCHEDULE: begin
							begin_find = 1'b1;
							state_d    = dtq_pkg::ST_FIND_FREE;
						end
						dtq_pkg::MODE_CANCEL: begin
							emit          = 1'b1;
							result_d.slot = item.cancel_slot;
							result_d.last = 1'b1;
							valid_idx     = cs_idx;
							if (cs_in_range && valid_q[cs_idx]) begin
								clr_valid     = 1'b1;
								result_d.kind = dtq_pkg::KIND_CANCELLED;
							end else begin
								result_d.kind = dtq_pkg::KIND_CANCEL_EMPTY;
							end
						end
						dtq_pkg::MODE_EXPIRE: begin
							begin_scan = 1'b1;
							state_d    = dtq_pkg::ST_SCAN;
						end
						default: begin
							state_d = dtq_pkg::ST_IDLE;
						end
					endcase
				end
			end
			dtq_pkg::ST_FIND_FREE: begin
				if (!valid_q[scan_idx_q]) begin
					ram_we        = 1'b1;
					set_valid     = 1'b1;
					emit          = 1'b1;
					result_d.kind = dtq_pkg::KIND_SCHEDULED;
					result_d.slot = dtq_pkg::SLOT_W'(scan_idx_q);
					result_d.last = 1'b1;
					state_d       = dtq_pkg::ST_IDLE;
				end else if (scan_idx_q == LAST_IDX) begin
					emit          = 1'b1;
					result_d.kind = dtq_pkg::KIND_TABLE_FULL;
					result_d.last = 1'b1;
					state_d       = dtq_pkg::ST_IDLE;
				end
			end
			dtq_pkg::ST_SCAN: begin
				if (rd_valid_s1 && rd_last_s1) begin
					state_d = dtq_pkg::ST_DECIDE;
				end
			end
			dtq_pkg::ST_DECIDE: begin
				if (!limit_hit && best_found_q && overdue) begin
					// Fire the earliest task, then search again.
					fire                    = 1'b1;
					clr_valid               = 1'b1;
					valid_idx               = best_idx_q;
					emit                    = 1'b1;
					result_d.kind           = dtq_pkg::KIND_FIRED;
					result_d.slot           = dtq_pkg::SLOT_W'(best_idx_q);
					result_d.fired_handler  = best_q.handler;
					result_d.fired_argument = best_q.argument;
					begin_scan              = 1'b1;
					state_d                 = dtq_pkg::ST_SCAN;
				end else begin
					emit          = 1'b1;
					result_d.kind = dtq_pkg::KIND_DONE;
					result_d.last = 1'b1;
					if (!best_found_q) begin
						result_d.time_to_next = dtq_pkg::TIME_MAX;
					end else if (overdue) begin
						result_d.time_to_next = '0;
					end else begin
						result_d.time_to_next = best_q.deadline - item_q.now_ms;
					end
					state_d = dtq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dtq_pkg::ST_IDLE;
			end
		endcase
	end

	// Occupancy, scan counter, read valid, limit, fired count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q         <= '0;
			scan_idx_q      <= '0;
			scan_issue_q    <= 1'b0;
			limit_q         <= '0;
			fired_q         <= '0;
			result_strobe_q <= 1'b0;
			best_found_q    <= 1'b0;
			rd_valid_s1     <= 1'b0;
		end else begin
			result_strobe_q <= emit;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (set_valid) begin
				valid_q[valid_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[valid_idx] <= 1'b0;
			end
			if (take_item) begin
				fired_q <= '0;
			end else if (fire) begin
				fired_q <= fired_q + 1'b1;
			end
			// Read pipeline: while a scan issues reads, one entry leaves the RAM each cycle.
			rd_valid_s1 <= ram_re;
			if (begin_scan || begin_find) begin
				scan_idx_q   <= '0;
				scan_issue_q <= begin_scan;
				best_found_q <= 1'b0;
			end else begin
				if ((state_q == dtq_pkg::ST_FIND_FREE) && (scan_idx_q != LAST_IDX)) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (ram_re) begin
					if (scan_idx_q == LAST_IDX) begin
						scan_issue_q <= 1'b0;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				if (rd_valid_s1 && better) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_item) begin
			item_q <= item;
		end
		if (emit) begin
			result_q <= result_d;
		end
		if (ram_re) begin
			rd_idx_s1  <= scan_idx_q;
			rd_last_s1 <= (scan_idx_q == LAST_IDX);
		end
		if (rd_valid_s1 && better) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_entry;
		end
	end

	assign busy          = (state_q != dtq_pkg::ST_IDLE);
	assign cfg_ready     = (state_q == dtq_pkg::ST_IDLE);
	assign result_strobe = result_strobe_q;
	assign result        = result_q;

endmodule

`default_nettype wire

// ----- tb/deadline_task_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline task queue result checker
// Watches the item, result and limit channels of the deadline task queue. It
// keeps its own copy of the task table and the expire limit, works out the
// results of every accepted operation and compares each result transfer,
// field by field and in order, with the oldest outstanding result.
// ----------------------------------------------------------------------------
module deadline_task_queue_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  dtq_pkg::item_t                 item,
	input  logic                           result_strobe,
	input  dtq_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [dtq_pkg::LIMIT_W-1:0]    cfg_data,
	output int                             pending,
	output int                             errors
);
	import dtq_pkg::*;

	// Shadow task table and expire limit.
	logic               task_live     [CAPACITY];
	logic [TIME_W-1:0]  task_deadline [CAPACITY];
	logic [HND_W-1:0]   task_handler  [CAPACITY];
	logic [ARG_W-1:0]   task_argument [CAPACITY];
	logic [LIMIT_W-1:0] fire_limit;

	// Results owed by the block, oldest first.
	result_t owed_results [$];

	// Live slot with the earliest deadline, lower index on ties; -1 if empty.
	function automatic int earliest_slot();
		int best;
		int i;
		best = -1;
		for (i = 0; i < CAPACITY; i++) begin
			if (task_live[i] && (best < 0 || task_deadline[i] < task_deadline[best])) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic void count_failure(input string msg);
		if (errors < 10) begin
			$display("%s", msg);
		end
		errors++;
	endfunction

	// Applies one accepted operation to the table and queues its results.
	task automatic apply_operation(input item_t op);
		int              idx;
		int              i;
		int              fired;
		logic            firing;
		logic [TIME_W:0] sum;
		result_t         res;
		idx = -1;
		fired = 0;
		res = '0;
		case (op.mode)
			MODE_SCHEDULE: begin
				for (i = 0; i < CAPACITY; i++) begin
					if (!task_live[i] && idx < 0) begin
						idx = i;
					end
				end
				res.last = 1'b1;
				if (idx < 0) begin
					res.kind = KIND_TABLE_FULL;
				end else begin
					// The deadline saturates instead of wrapping.
					sum = {1'b0, op.now_ms} + (TIME_W + 1)'(op.delay_ms);
					task_live[idx] = 1'b1;
					task_deadline[idx] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
					task_handler[idx] = op.handler_id;
					task_argument[idx] = op.argument;
					res.kind = KIND_SCHEDULED;
					res.slot = SLOT_W'(idx);
				end
				owed_results.push_back(res);
			end
			MODE_CANCEL: begin
				res.last = 1'b1;
				res.slot = op.cancel_slot;
				if (int'(op.cancel_slot) < CAPACITY && task_live[op.cancel_slot]) begin
					task_live[op.cancel_slot] = 1'b0;
					res.kind = KIND_CANCELLED;
				end else begin
					res.kind = KIND_CANCEL_EMPTY;
				end
				owed_results.push_back(res);
			end
			MODE_EXPIRE: begin
				// Fire overdue tasks earliest first until the limit is reached or none is overdue.
				firing = 1'b1;
				while (firing) begin
					if (fire_limit != '0 && fired == int'(fire_limit)) begin
						firing = 1'b0;
					end else begin
						idx = earliest_slot();
						if (idx < 0 || !(op.now_ms > task_deadline[idx])) begin
							firing = 1'b0;
						end else begin
							task_live[idx] = 1'b0;
							res = '0;
							res.kind = KIND_FIRED;
							res.slot = SLOT_W'(idx);
							res.fired_handler = task_handler[idx];
							res.fired_argument = task_argument[idx];
							owed_results.push_back(res);
							fired++;
						end
					end
				end
				// Closing result with the time left to the next deadline.
				res = '0;
				res.kind = KIND_DONE;
				res.last = 1'b1;
				idx = earliest_slot();
				if (idx < 0) begin
					res.time_to_next = TIME_MAX;
				end else if (op.now_ms > task_deadline[idx]) begin
					res.time_to_next = '0;
				end else begin
					res.time_to_next = task_deadline[idx] - op.now_ms;
				end
				owed_results.push_back(res);
			end
			default: begin
				// The unused mode leaves everything as it is.
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int      i;
		if (!arst_n) begin
			for (i = 0; i < CAPACITY; i++) begin
				task_live[i] = 1'b0;
			end
			fire_limit = '0;
			owed_results.delete();
			pending = 0;
			errors = 0;
		end else begin
			// A result transfer always belongs to an item accepted earlier.
			if (result_strobe) begin
				if (owed_results.size() == 0) begin
					count_failure($sformatf(
						"unexpected result: kind %0d slot %0d hnd %0h arg %0h ttn %0h last %0b",
						result.kind, result.slot, result.fired_handler,
						result.fired_argument, result.time_to_next, result.last));
				end else begin
					want = owed_results.pop_front();
					if (result.kind !== want.kind || result.slot !== want.slot ||
						result.fired_handler !== want.fired_handler ||
						result.fired_argument !== want.fired_argument ||
						result.time_to_next !== want.time_to_next ||
						result.last !== want.last) begin
						count_failure($sformatf(
							{"result mismatch: expected kind %0d slot %0d hnd %0h arg %0h",
							" ttn %0h last %0b, got kind %0d slot %0d hnd %0h arg %0h",
							" ttn %0h last %0b"},
							want.kind, want.slot, want.fired_handler, want.fired_argument,
							want.time_to_next, want.last, result.kind, result.slot,
							result.fired_handler, result.fired_argument,
							result.time_to_next, result.last));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				fire_limit = cfg_data;
			end
			if (start && !busy) begin
				apply_operation(item);
			end
			pending = owed_results.size();
		end
	end

endmodule

// ----- tb/tb_deadline_task_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline task queue testbench
// Drives a directed sequence (empty queue, saturated deadline, equal
// deadlines, full table, cancels of live and empty slots, the unused mode)
// and then random phases under several expire limits, with random gaps on
// the item port. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_deadline_task_queue_unit;
	import dtq_pkg::*;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         PHASE_OPS     = 25;
	localparam int         SETTLE_CYCLES = 40;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic               busy;
	item_t              item      = '0;
	logic               result_strobe;
	result_t            result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data  = '0;
	int                 pending;
	int                 errors;
	int                 quiet_cycles = 0;
	// Time base that well-formed traffic moves forward.
	logic [TIME_W-1:0]  clock_ms  = '0;

	deadline_task_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	deadline_task_queue_checker results_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.errors        (errors)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: ends the run after too many cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("deadline_task_queue_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_op(input logic [1:0] mode, input logic [TIME_W-1:0] now,
		input logic [DELAY_W-1:0] delay, input logic [HND_W-1:0] hnd,
		input logic [ARG_W-1:0] arg, input logic [SLOT_W-1:0] slot);
		item_t op;
		op.mode = mode;
		op.now_ms = now;
		op.delay_ms = delay;
		op.handler_id = hnd;
		op.argument = arg;
		op.cancel_slot = slot;
		return op;
	endfunction

	// Mostly well-formed traffic around the time base, plus noise.
	function automatic item_t random_op();
		item_t       op;
		logic [63:0] wide;
		int          pick;
		wide = {$urandom, $urandom};
		op.mode = MODE_SCHEDULE;
		op.now_ms = wide[TIME_W-1:0];
		op.delay_ms = $urandom;
		op.handler_id = HND_W'($urandom);
		op.argument = $urandom;
		op.cancel_slot = SLOT_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			op.now_ms = clock_ms;
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				op.delay_ms = $urandom_range(0, 300);
			end else if (pick == 8) begin
				op.delay_ms = '0;
			end
		end else if (pick < 60) begin
			op.mode = MODE_CANCEL;
		end else if (pick < 90) begin
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 200));
			op.mode = MODE_EXPIRE;
			op.now_ms = clock_ms;
		end else if (pick < 97) begin
			op.mode = 2'($urandom_range(0, 2));
		end else begin
			op.mode = MODE_UNUSED;
		end
		return op;
	endfunction

	// Holds start until the item transfer completes.
	task automatic send_op(input item_t op);
		item <= op;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Random gap after a transfer, mostly short.
	task automatic idle_gap();
		int pick;
		int cycles;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			cycles = 0;
		end else if (pick < 85) begin
			cycles = $urandom_range(1, 3);
		end else if (pick < 97) begin
			cycles = $urandom_range(4, 12);
		end else begin
			cycles = $urandom_range(20, 60);
		end
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stops sending until every owed result has arrived, then settles.
	task automatic drain(input int settle);
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (settle + 1) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		item_t              op;
		int                 k;
		int                 sent;
		int                 phase;
		logic [LIMIT_W-1:0] limits [4];
		limits[0] = LIMIT_W'(1);
		limits[1] = '0;
		limits[2] = LIMIT_W'($urandom_range(2, 15));
		limits[3] = LIMIT_W'(16);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Expire on an empty queue, then cancel of an empty top slot.
		send_op(make_op(MODE_EXPIRE, '0, '0, '0, '0, '0));
		idle_gap();
		send_op(make_op(MODE_CANCEL, TIME_MAX, '1, '1, '1, SLOT_W'(15)));
		idle_gap();
		// Deadline past the largest time saturates.
		send_op(make_op(MODE_SCHEDULE, TIME_MAX, '1, '1, '1, '0));
		idle_gap();
		send_op(make_op(MODE_SCHEDULE, 48'd100, '0, '0, '0, '0));
		idle_gap();
		// Equal deadlines in the remaining slots fill the table.
		for (k = 2; k < CAPACITY; k++) begin
			send_op(make_op(MODE_SCHEDULE, 48'd100, 32'd5, HND_W'(k),
				ARG_W'(k) * 32'h01010101, '0));
			idle_gap();
		end
		send_op(make_op(MODE_SCHEDULE, 48'd100, 32'd7, 8'h5a, 32'h12345678, '0));
		idle_gap();
		send_op(make_op(MODE_CANCEL, '0, '0, '0, '0, SLOT_W'(3)));
		idle_gap();
		send_op(make_op(MODE_CANCEL, '0, '0, '0, '0, SLOT_W'(3)));
		idle_gap();
		send_op(make_op(MODE_UNUSED, 48'h123456789abc, '1, '1, '1, '1));
		drain(SETTLE_CYCLES);
		// A limit above the number of due tasks fires them all.
		write_limit(LIMIT_W'(16));
		send_op(make_op(MODE_EXPIRE, 48'd106, '0, '0, '0, '0));
		idle_gap();
		// Deadline equal to now does not fire.
		send_op(make_op(MODE_EXPIRE, TIME_MAX, '0, '0, '0, '0));
		idle_gap();
		send_op(make_op(MODE_CANCEL, '0, '0, '0, '0, '0));

		// Random phases, one per limit setting.
		for (phase = 0; phase < 4; phase++) begin
			drain(SETTLE_CYCLES);
			write_limit(limits[phase]);
			if (phase == 3) begin
				clock_ms = TIME_MAX - TIME_W'($urandom_range(0, 2000));
			end else begin
				clock_ms = TIME_W'($urandom_range(0, 100000));
			end
			sent = 0;
			while (sent < PHASE_OPS) begin
				op = random_op();
				send_op(op);
				if (op.mode != MODE_UNUSED) begin
					sent++;
				end
				// Now and then let every owed result arrive first.
				if ($urandom_range(0, 19) == 0) begin
					drain(0);
				end else if (sent % 20 >= 6) begin
					idle_gap();
				end
			end
		end

		drain(SETTLE_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("deadline_task_queue_unit verification clean");
		end else begin
			$display("deadline_task_queue_unit verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/deadline_task_queue_unit.sv
tb/deadline_task_queue_checker.sv
tb/tb_deadline_task_queue_unit.sv
